FILE: src/aapr_pkg.sv
// Package for axis-angle point rotation: constants, CORDIC table, stage word type.
`timescale 1ns / 1ps
package aapr_pkg;
	localparam int CordicStagesDef = 16;
	localparam int AtanEntries = 24;
	localparam logic signed [17:0] One14 = 18'sd16384;
	localparam logic signed [24:0] Deg360 = 25'sd92160;
	localparam logic signed [24:0] Deg180 = 25'sd46080;
	localparam logic signed [24:0] Deg90 = 25'sd23040;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [25:0] z;
		logic neg;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} cword_t;

	function automatic logic signed [25:0] atan_deg(input int i);
		logic signed [25:0] t [0:23];
		t = '{26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
			26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
			26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
			26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0};
		return t[i];
	endfunction
endpackage

FILE: src/axis_angle_point_rotation_core.sv
// Top level: angle reduction, CORDIC cell chain, matrix build and point rotation.
// Use: drive the word on the input ports with start high; busy is always low, so a
// word is taken every cycle. Each result appears for one cycle with done high.
// Pipeline: angle-reduction stages, one register per CORDIC cell (CORDIC_STAGES,
// capped at 24), then sin/cos, matrix, dot-product and output stages.
// Throughput: one word per cycle, set by the fully pipelined cell chain.
// Reset clears all valid flags; no results emerge until new words enter.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module axis_angle_point_rotation_core #(
	parameter int CORDIC_STAGES = aapr_pkg::CordicStagesDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] axis_x,
	input logic signed [15:0] axis_y,
	input logic signed [15:0] axis_z,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic signed [23:0] angle_deg,
	output logic done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22
);
	import aapr_pkg::*;
	localparam int N = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

	assign busy = 1'b0;

	// angle reduction: floor mod 360 via reciprocal estimate and correction
	logic v_s1, v_s2, v_s3;
	logic signed [23:0] a_s1;
	logic signed [15:0] k_s1;
	cword_t w_s1, w_s2, w_s3, w3n;
	logic signed [24:0] r_s2;
	logic signed [41:0] prod;
	logic signed [24:0] rm, rr;
	logic signed [25:0] zf;
	logic nf;
	assign prod = 42'(angle_deg) * 42'sd46603; // 2^32/92160
	always_comb begin
		rm = 25'(a_s1) - 25'(k_s1 * 25'(Deg360) >>> 0);
		if (rm < 0) rm = rm + Deg360;
		if (rm >= Deg360) rm = rm - Deg360;
	end
	always_comb begin
		rr = r_s2;
		nf = 1'b0;
		if (rr >= Deg180) rr = rr - Deg360;
		if (rr > Deg90) begin
			rr = rr - Deg180;
			nf = 1'b1;
		end else if (rr < -Deg90) begin
			rr = rr + Deg180;
			nf = 1'b1;
		end
		zf = 26'(rr) <<< 8;
		w3n = w_s2;
		w3n.z = zf;
		w3n.neg = nf;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		a_s1 <= angle_deg;
		k_s1 <= 16'(prod >>> 32);
		w_s1 <= '{x: CordicGain, y: '0, z: '0, neg: 1'b0, ax: axis_x, ay: axis_y,
			az: axis_z, px: point_x, py: point_y, pz: point_z};
		r_s2 <= rm;
		w_s2 <= w_s1;
		w_s3 <= w3n;
	end

	logic vc [0:N];
	cword_t wc [0:N];
	assign vc[0] = v_s3;
	assign wc[0] = w_s3;
	for (genvar i = 0; i < N; i++) begin : g_cell
		aapr_cell #(.Shift(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .vld(vc[i]), .d(wc[i]),
			.vld_s1(vc[i + 1]), .q_s1(wc[i + 1])
		);
	end

	// sin/cos round and clamp
	function automatic logic signed [17:0] rc(input logic signed [33:0] v, input logic ng);
		logic signed [34:0] t;
		logic signed [17:0] r;
		t = (35'(v) + 35'sd32768) >>> 16;
		r = (t > 35'(One14)) ? One14 : ((t < -35'(One14)) ? -One14 : 18'(t));
		return ng ? -r : r;
	endfunction

	logic v_s4, v_s5, v_s6, v_s7;
	logic signed [17:0] s_s4, c_s4;
	cword_t w_s4;
	logic signed [15:0] ax_s4, ay_s4, az_s4;
	always_ff @(posedge clk) begin
		s_s4 <= rc(wc[N].y, wc[N].neg);
		c_s4 <= rc(wc[N].x, wc[N].neg);
		w_s4 <= wc[N];
	end
	assign ax_s4 = w_s4.ax;
	assign ay_s4 = w_s4.ay;
	assign az_s4 = w_s4.az;

	// products: (1-c)*a*b split over two stages
	logic signed [18:0] omc;
	assign omc = 19'(One14) - 19'(c_s4);
	logic signed [35:0] oa_s5, ob_s5, oc_s5;
	logic signed [33:0] sx_s5, sy_s5, sz_s5;
	logic signed [17:0] c_s5;
	cword_t w_s5;
	always_ff @(posedge clk) begin
		oa_s5 <= 36'(omc) * 36'(ax_s4);
		ob_s5 <= 36'(omc) * 36'(ay_s4);
		oc_s5 <= 36'(omc) * 36'(az_s4);
		sx_s5 <= 34'(ax_s4) * 34'(s_s4);
		sy_s5 <= 34'(ay_s4) * 34'(s_s4);
		sz_s5 <= 34'(az_s4) * 34'(s_s4);
		c_s5 <= c_s4;
		w_s5 <= w_s4;
	end

	function automatic logic signed [15:0] ent(input logic signed [35:0] o,
			input logic signed [15:0] b, input logic signed [53:0] add);
		logic signed [53:0] t;
		logic signed [53:0] r;
		t = 54'(o) * 54'(b) + add;
		r = (t + 54'sd134217728) >>> 28;
		if (r > 54'(One14)) return 16'(One14);
		if (r < -54'(One14)) return -16'(One14);
		return 16'(r);
	endfunction

	logic signed [53:0] ct, axs, ays, azs;
	assign ct = 54'(c_s5) <<< 28;
	assign axs = 54'(sx_s5) <<< 14;
	assign ays = 54'(sy_s5) <<< 14;
	assign azs = 54'(sz_s5) <<< 14;
	logic signed [15:0] m_s6 [0:8];
	cword_t w_s6;
	always_ff @(posedge clk) begin
		m_s6[0] <= ent(oa_s5, w_s5.ax, ct);
		m_s6[1] <= ent(oa_s5, w_s5.ay, -azs);
		m_s6[2] <= ent(oc_s5, w_s5.ax, ays);
		m_s6[3] <= ent(oa_s5, w_s5.ay, azs);
		m_s6[4] <= ent(ob_s5, w_s5.ay, ct);
		m_s6[5] <= ent(ob_s5, w_s5.az, -axs);
		m_s6[6] <= ent(oc_s5, w_s5.ax, -ays);
		m_s6[7] <= ent(ob_s5, w_s5.az, axs);
		m_s6[8] <= ent(oc_s5, w_s5.az, ct);
		w_s6 <= w_s5;
	end

	logic signed [47:0] pp_s7 [0:8];
	logic signed [15:0] m_s7 [0:8];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			pp_s7[3 * r] <= 48'(m_s6[3 * r]) * 48'(w_s6.px);
			pp_s7[3 * r + 1] <= 48'(m_s6[3 * r + 1]) * 48'(w_s6.py);
			pp_s7[3 * r + 2] <= 48'(m_s6[3 * r + 2]) * 48'(w_s6.pz);
		end
		m_s7 <= m_s6;
	end

	function automatic logic signed [31:0] dot(input logic signed [47:0] a,
			input logic signed [47:0] b, input logic signed [47:0] c);
		logic signed [49:0] t;
		t = (50'(a) + 50'(b) + 50'(c) + 50'sd8192) >>> 14;
		if (t > 50'sd2147483647) return 32'sh7fffffff;
		if (t < -50'sd2147483648) return 32'sh80000000;
		return 32'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= vc[N];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		rot_x <= dot(pp_s7[0], pp_s7[1], pp_s7[2]);
		rot_y <= dot(pp_s7[3], pp_s7[4], pp_s7[5]);
		rot_z <= dot(pp_s7[6], pp_s7[7], pp_s7[8]);
		m00 <= m_s7[0];
		m01 <= m_s7[1];
		m02 <= m_s7[2];
		m10 <= m_s7[3];
		m11 <= m_s7[4];
		m12 <= m_s7[5];
		m20 <= m_s7[6];
		m21 <= m_s7[7];
		m22 <= m_s7[8];
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n) v_s4 |-> ##4 done)
		else $error("result lost");
	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384))
		else $error("diag out of range");
endmodule

FILE: src/aapr_cell.sv
// One CORDIC rotation cell with its pipeline register.
`timescale 1ns / 1ps
module aapr_cell #(
	parameter int Shift = 0
) (
	input logic clk,
	input logic arst_n,
	input logic vld,
	input aapr_pkg::cword_t d,
	output logic vld_s1,
	output aapr_pkg::cword_t q_s1
);
	import aapr_pkg::*;
	cword_t n;
	always_comb begin
		n = d;
		if (d.z >= 0) begin
			n.x = d.x - (d.y >>> Shift);
			n.y = d.y + (d.x >>> Shift);
			n.z = d.z - atan_deg(Shift);
		end else begin
			n.x = d.x + (d.y >>> Shift);
			n.y = d.y - (d.x >>> Shift);
			n.z = d.z + atan_deg(Shift);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld;
	end
	always_ff @(posedge clk) q_s1 <= n;
endmodule

FILE: tb/tb.sv
// Testbench for the axis-angle point rotation core: random and directed words, scoreboard check.
`timescale 1ns / 1ps

typedef struct {
	logic signed [31:0] rx, ry, rz;
	logic signed [15:0] m [9];
} rot_result_t;

class rotation_scoreboard;
	rot_result_t pending[$];
	int errors;

	function longint floor_shift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function longint rnd_shift(longint v, int s);
		return floor_shift(v + (longint'(1) <<< (s - 1)), s);
	endfunction

	function longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function void note_word(logic signed [15:0] ax, ay, az,
		logic signed [31:0] px, py, pz, logic signed [23:0] ang);
		longint atan_tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
			7, 4, 2, 1, 0};
		longint r, x, y, z, dx, dy, s, c, oc, ct, a, b, e;
		longint m [9];
		longint p [3];
		longint acc;
		bit neg;
		rot_result_t res;
		r = longint'(ang) % 92160;
		if (r < 0) r += 92160;
		if (r >= 46080) r -= 92160;
		neg = 0;
		if (r > 23040) begin
			r -= 46080; neg = 1;
		end else if (r < -23040) begin
			r += 46080; neg = 1;
		end
		z = r * 256; x = 652032874; y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(y, i); dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		c = clip(rnd_shift(x, 16), -16384, 16384);
		s = clip(rnd_shift(y, 16), -16384, 16384);
		if (neg) begin
			c = -c; s = -s;
		end
		oc = 16384 - c; ct = c * (longint'(1) <<< 28);
		a = ax; b = ay; e = az;
		m[0] = clip(rnd_shift(oc * a * a + ct, 28), -16384, 16384);
		m[1] = clip(rnd_shift(oc * a * b - e * s * 16384, 28), -16384, 16384);
		m[2] = clip(rnd_shift(oc * e * a + b * s * 16384, 28), -16384, 16384);
		m[3] = clip(rnd_shift(oc * a * b + e * s * 16384, 28), -16384, 16384);
		m[4] = clip(rnd_shift(oc * b * b + ct, 28), -16384, 16384);
		m[5] = clip(rnd_shift(oc * b * e - a * s * 16384, 28), -16384, 16384);
		m[6] = clip(rnd_shift(oc * e * a - b * s * 16384, 28), -16384, 16384);
		m[7] = clip(rnd_shift(oc * b * e + a * s * 16384, 28), -16384, 16384);
		m[8] = clip(rnd_shift(oc * e * e + ct, 28), -16384, 16384);
		p[0] = px; p[1] = py; p[2] = pz;
		for (int k = 0; k < 9; k++) res.m[k] = m[k][15:0];
		for (int row = 0; row < 3; row++) begin
			acc = m[row*3] * p[0] + m[row*3+1] * p[1] + m[row*3+2] * p[2];
			acc = clip(rnd_shift(acc, 14), -64'sd2147483648, 64'sd2147483647);
			if (row == 0) res.rx = acc[31:0];
			else if (row == 1) res.ry = acc[31:0];
			else res.rz = acc[31:0];
		end
		pending.push_back(res);
	endfunction

	function void check_word(rot_result_t got);
		rot_result_t exp_r;
		if (pending.size() == 0) begin
			$error("unexpected result word");
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.rx !== exp_r.rx) begin
			$error("rot_x exp %0d got %0d", exp_r.rx, got.rx); errors++;
		end
		if (got.ry !== exp_r.ry) begin
			$error("rot_y exp %0d got %0d", exp_r.ry, got.ry); errors++;
		end
		if (got.rz !== exp_r.rz) begin
			$error("rot_z exp %0d got %0d", exp_r.rz, got.rz); errors++;
		end
		for (int k = 0; k < 9; k++)
			if (got.m[k] !== exp_r.m[k]) begin
				$error("m%0d%0d exp %0d got %0d", k / 3, k % 3, exp_r.m[k], got.m[k]);
				errors++;
			end
	endfunction
endclass

module tb;
	logic clk, arst_n, start, busy, done;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [23:0] angle_deg;
	logic signed [31:0] rot_x, rot_y, rot_z;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	rotation_scoreboard rot_sb;

	axis_angle_point_rotation_core dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		rot_result_t got;
		if (arst_n && done) begin
			got.rx = rot_x; got.ry = rot_y; got.rz = rot_z;
			got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			rot_sb.check_word(got);
		end
	end

	function automatic logic signed [15:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_point();
		case ($urandom_range(0, 4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] pick_angle();
		case ($urandom_range(0, 4))
			0: return 24'($urandom_range(0, 8) * 11520);
			1: return -24'($urandom_range(0, 8) * 11520);
			2: return 24'($urandom_range(0, 184320)) - 24'sd92160;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_word(logic signed [15:0] ax, ay, az,
		logic signed [31:0] px, py, pz, logic signed [23:0] ang);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			($urandom_range(0, 1) ? 0 : $urandom_range(0, 2));
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		axis_x <= ax; axis_y <= ay; axis_z <= az;
		point_x <= px; point_y <= py; point_z <= pz;
		angle_deg <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		rot_sb.note_word(ax, ay, az, px, py, pz, ang);
	endtask

	initial begin
		logic signed [23:0] dir_ang [12] = '{24'sd0, 24'sd23040, 24'sd23041, 24'sd46080,
			-24'sd23040, -24'sd23041, 24'sd92160, -24'sd92160, 24'sh7fffff,
			24'sh800000, 24'sd69120, 24'sd11520};
		rot_sb = new();
		arst_n = 0; start = 0;
		axis_x = 0; axis_y = 0; axis_z = 0;
		point_x = 0; point_y = 0; point_z = 0; angle_deg = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_ang[i])
			send_word(16'sd0, 16'sd0, 16'sd16384, 32'sh7fffffff, 32'sh80000000,
				32'sd65536, dir_ang[i]);
		send_word(16'sd16384, 16'sd16384, 16'sd16384, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 24'sd11520);
		send_word(-16'sd32768, 16'sd32767, -16'sd16384, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 24'sd34560);
		send_word(16'sd11585, 16'sd11585, 16'sd0, 32'sd65536, -32'sd65536, 32'sd0,
			24'sd23040);
		send_word(16'sd9459, -16'sd9459, 16'sd9459, -32'sd1, 32'sd1, 32'sd0,
			-24'sd7680);
		for (int n = 0; n < 1500; n++)
			send_word(pick_axis(), pick_axis(), pick_axis(), pick_point(), pick_point(),
				pick_point(), pick_angle());
		start <= 0;
		while (rot_sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (rot_sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule

FILE: axis_angle_point_rotation_core.f
src/aapr_pkg.sv
src/aapr_cell.sv
src/axis_angle_point_rotation_core.sv
tb/tb.sv
